### src/spsdc_pkg.sv
// Shared constants and types for the stable pair sorter.
package spsdc_pkg;

   localparam int CAPACITY = 64;   // number of sort cells, 2..64
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int CNT_W    = 7;    // distinct count, holds 0..64

   // One stored pair.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
   } entry_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic             ins;     // insert new pair
      logic             shift;   // drain: move every entry one cell toward the head
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
   } cell_ctl_type;

endpackage

### src/spsdc_if.sv
// Handshake interfaces for the request and response channels.
interface spsdc_req_if;
   logic                         valid;
   logic                         ready;
   logic [spsdc_pkg::KEY_W-1:0]  doc_key;
   logic [spsdc_pkg::VAL_W-1:0]  pos_value;
   logic                         last_in;

   modport source (output valid, doc_key, pos_value, last_in, input ready);
   modport sink   (input valid, doc_key, pos_value, last_in, output ready);
endinterface

interface spsdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spsdc_pkg::KEY_W-1:0]  doc_out;
   logic [spsdc_pkg::VAL_W-1:0]  pos_out;
   logic                         last_out;
   logic [spsdc_pkg::CNT_W-1:0]  distinct_docs;
   logic                         overflow;

   modport source (output valid, doc_out, pos_out, last_out, distinct_docs, overflow,
                   input ready);
   modport sink   (input valid, doc_out, pos_out, last_out, distinct_docs, overflow,
                   output ready);
endinterface

### src/spsdc_cell.sv
// One insertion-sort cell: holds a pair, inserts in order, shifts on drain.
module spsdc_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  spsdc_pkg::cell_ctl_type  ctl,
   input  logic                     left_gt,
   input  spsdc_pkg::entry_type     left_entry,
   input  spsdc_pkg::entry_type     right_entry,
   output logic                     gt,
   output spsdc_pkg::entry_type     entry,
   output logic                     hit
);

   logic                          valid_ff, valid_in;
   logic [spsdc_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [spsdc_pkg::VAL_W-1:0]   val_ff, val_in;
   logic                          hit_ff, hit_in;

   // Empty or strictly greater: new pair goes in front (equal keys stay ahead).
   assign gt = !valid_ff || (key_ff > ctl.key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      hit_in   = valid_ff && (key_ff == ctl.key);
      if (ctl.ins) begin
         if (gt && left_gt) begin
            valid_in = left_entry.valid;
            key_in   = left_entry.key;
            val_in   = left_entry.val;
         end else if (gt) begin
            valid_in = 1'b1;
            key_in   = ctl.key;
            val_in   = ctl.val;
         end
      end else if (ctl.shift) begin
         valid_in = right_entry.valid;
         key_in   = right_entry.key;
         val_in   = right_entry.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      val_ff <= val_in;
      hit_ff <= hit_in;
   end

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.val   = val_ff;
   assign hit         = hit_ff;

endmodule

### src/stable_pair_sorter_with_distinct_count.sv
// Top level: stable key/value sorter built from a chain of insertion cells.
//
// Usage:
//  - req_bus carries (doc_key, pos_value, last_in) items. One item is taken per
//    cycle while loading; each is inserted into a row of CAPACITY cells that
//    keeps the set sorted by doc_key, equal keys in arrival order.
//  - Items past CAPACITY are dropped and set the overflow flag; a closing item
//    (last_in) still closes the set when dropped.
//  - After the closing item, req_bus.ready stays low while the set drains.
//    The head cell moves into the output register once the drain starts, then
//    one result per cycle while rsp_bus is ready, as the row shifts one cell
//    toward the head with each move. last_out marks the final result.
//  - distinct_docs and overflow are constant while drain results are valid.
//  - rsp_bus stalls hold the output register and freeze the row; no result is
//    lost. Loading resumes in the cycle after the final result is taken.
//  - Synchronous reset empties every cell and clears the count and flag.
//    No clearing pass is needed.
module stable_pair_sorter_with_distinct_count (
   input  logic           clock,
   input  logic           reset,
   spsdc_req_if.sink      req_bus,
   spsdc_rsp_if.source    rsp_bus
);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   localparam int CAP = spsdc_pkg::CAPACITY;

   state_type                     state_ff, state_in;
   logic                          pend_ff, pend_in;     // last insert awaits dup check
   logic [spsdc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                          dropped_ff, dropped_in;
   logic                          out_valid_ff, out_valid_in;
   logic [spsdc_pkg::KEY_W-1:0]   out_doc_ff, out_doc_in;
   logic [spsdc_pkg::VAL_W-1:0]   out_pos_ff, out_pos_in;
   logic                          out_last_ff, out_last_in;

   spsdc_pkg::cell_ctl_type       ctl;
   spsdc_pkg::entry_type          ent_w [CAP];
   logic [CAP-1:0]                gt_w;
   logic [CAP-1:0]                hit_w;

   logic req_acc, rsp_acc, full, ins, advance, final_acc, dup;

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_acc   = req_bus.valid && req_bus.ready;
   assign full      = ent_w[CAP-1].valid;
   assign ins       = req_acc && !full;
   assign rsp_acc   = out_valid_ff && rsp_bus.ready;
   assign final_acc = rsp_acc && out_last_ff;
   // During drain, move the head into the output register whenever it is free.
   assign advance   = (state_ff == ST_DRAIN) && ent_w[0].valid &&
                      (!out_valid_ff || rsp_bus.ready);
   // Any cell whose registered hit shows it held the inserted key makes it a duplicate.
   assign dup       = |hit_w;

   assign ctl.ins   = ins;
   assign ctl.shift = advance;
   assign ctl.key   = req_bus.doc_key;
   assign ctl.val   = req_bus.pos_value;

   // Cell row: head at index 0, smallest key first.
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      spsdc_pkg::entry_type left_e, right_e;
      logic                 left_g;
      if (i == 0) begin : g_head
         assign left_e = '0;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = ent_w[i-1];
         assign left_g = gt_w[i-1];
      end
      if (i == CAP-1) begin : g_tail
         assign right_e = '0;
      end else begin : g_body
         assign right_e = ent_w[i+1];
      end
      spsdc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_gt     (left_g),
         .left_entry  (left_e),
         .right_entry (right_e),
         .gt          (gt_w[i]),
         .entry       (ent_w[i]),
         .hit         (hit_w[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      pend_in      = ins;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      out_valid_in = out_valid_ff;
      out_doc_in   = out_doc_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_bus.last_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (final_acc) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (pend_ff && !dup) begin
         count_in = count_ff + 1'b1;
      end
      if (req_acc && full) begin
         dropped_in = 1'b1;
      end
      if (final_acc) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         out_doc_in   = ent_w[0].key;
         out_pos_in   = ent_w[0].val;
         out_last_in  = !ent_w[1].valid;
      end else if (rsp_acc) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
      out_doc_ff  <= out_doc_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.doc_out       = out_doc_ff;
   assign rsp_bus.pos_out       = out_pos_ff;
   assign rsp_bus.last_out      = out_last_ff;
   assign rsp_bus.distinct_docs = count_ff;
   assign rsp_bus.overflow      = dropped_ff;

`ifndef NO_ASSERTIONS
   a_out_in_drain: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == ST_DRAIN))
      else $error("result valid outside drain");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (advance && ent_w[1].valid) |-> (ent_w[0].key <= ent_w[1].key))
      else $error("cell row out of order");

   a_empty_after_final: assert property (@(posedge clock) disable iff (reset)
      final_acc |=> !ent_w[0].valid)
      else $error("cells not empty after final result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spsdc_pkg::CNT_W'(CAP))
      else $error("distinct count beyond capacity");
`endif

endmodule
